@@ design/integer_matrix_multiply_macros.svh @@
`ifndef INTEGER_MATRIX_MULTIPLY_MACROS_SVH
`define INTEGER_MATRIX_MULTIPLY_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while in reset.
`define IMM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, clocked on i_clk, off while in reset.
`define IMM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ design/imm_pkg.sv @@
`default_nettype none

package imm_pkg;

    localparam int IDX_W     = 3;   // row / column index fields
    localparam int DIM_W     = 4;   // dimension registers
    localparam int OP_W      = 2;
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 32;  // result value field

    typedef enum logic [OP_W-1:0] {
        OP_LOAD_A   = 2'd0,
        OP_LOAD_B   = 2'd1,
        OP_MULTIPLY = 2'd2
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROWS_A = 2'd0,
        CFG_COLS_A = 2'd1,
        CFG_ROWS_B = 2'd2,
        CFG_COLS_B = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT,
        ST_OUT
    } t_state;

    // tags that travel with one operand pair through the MAC pipeline
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } t_mac_ctl;

    // zero acts as one, anything above the store size is clipped
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] raw,
                                                 input logic [DIM_W-1:0] max_dim);
        logic [DIM_W-1:0] res;
        res = raw;
        if (raw == '0) begin
            res = DIM_W'(1);
        end else if (raw > max_dim) begin
            res = max_dim;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ design/integer_matrix_multiply.sv @@
// Load word: accepted when idle, written straight into its store if its indices are in range.
// Multiply word: each result element issues cols_a operand pairs through the shared
// multiply-accumulate unit, passes the pipeline registers (RAM read, product, sum)
// and is held on the output until taken; a full product is rows_a*cols_b such elements.
// A dimension mismatch presents its single status word the cycle after acceptance.
// Synchronous active-low reset: dimension registers go to 1, control returns to
// idle; the stores are not cleared.
`default_nettype none

`include "integer_matrix_multiply_macros.svh"

module integer_matrix_multiply import imm_pkg::*; #(
    parameter int MAX_DIM    = 8,
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [DIM_W-1:0]        i_cfg_data,
    input  wire logic                    i_in_valid,
    output logic                         o_in_ready,
    input  wire logic [OP_W-1:0]         i_operation,
    input  wire logic [IDX_W-1:0]        i_row_index,
    input  wire logic [IDX_W-1:0]        i_col_index,
    input  wire logic signed [OUT_W-1:0] i_element_value,
    output logic                         o_out_valid,
    input  wire logic                    i_out_ready,
    output logic signed [OUT_W-1:0]      o_product_value,
    output logic [IDX_W-1:0]             o_out_row,
    output logic [IDX_W-1:0]             o_out_col,
    output logic                         o_last,
    output logic                         o_status
);

    localparam int DEPTH       = MAX_DIM * MAX_DIM;
    localparam int AW          = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int ADDR_CALC_W = 2 * IDX_W + 1;

    function automatic logic [AW-1:0] addr_of(input logic [IDX_W-1:0] row,
                                              input logic [IDX_W-1:0] col);
        logic [ADDR_CALC_W-1:0] full;
        full = ADDR_CALC_W'(row) * ADDR_CALC_W'(MAX_DIM) + ADDR_CALC_W'(col);
        return full[AW-1:0];
    endfunction

    t_state               r_state, n_state;
    logic [DIM_W-1:0]     r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    logic [IDX_W-1:0]     r_row, n_row;
    logic [IDX_W-1:0]     r_col, n_col;
    logic [IDX_W-1:0]     r_j, n_j;
    t_mac_ctl             r_rd_ctl;

    logic signed [OUT_W-1:0] r_out_value, n_out_value;
    logic [IDX_W-1:0]        r_out_row, n_out_row;
    logic [IDX_W-1:0]        r_out_col, n_out_col;
    logic                    r_out_last, n_out_last;
    logic                    r_out_status, n_out_status;

    logic                         w_accept, w_is_mult, w_mismatch;
    logic                         w_issue, w_issue_last, w_capture, w_out_take;
    logic                         w_we_a, w_we_b;
    logic [DATA_WIDTH-1:0]        w_a_data, w_b_data;
    logic signed [DATA_WIDTH-1:0] w_acc;
    logic                         w_mac_done;
    logic [DIM_W-1:0]             w_max_dim;

    assign w_max_dim    = DIM_W'(MAX_DIM);
    assign w_accept     = i_in_valid && o_in_ready;
    assign w_is_mult    = w_accept && (i_operation == OP_MULTIPLY);
    assign w_mismatch   = (r_cols_a != r_rows_b);
    assign w_issue_last = (DIM_W'(r_j) + DIM_W'(1)) == r_cols_a;
    assign w_out_take   = o_out_valid && i_out_ready;

    assign w_we_a = w_accept && (i_operation == OP_LOAD_A)
                 && (DIM_W'(i_row_index) < r_rows_a) && (DIM_W'(i_col_index) < r_cols_a);
    assign w_we_b = w_accept && (i_operation == OP_LOAD_B)
                 && (DIM_W'(i_row_index) < r_rows_b) && (DIM_W'(i_col_index) < r_cols_b);

    imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH), .AW(AW)) u_store_a (
        .i_clk   (i_clk),
        .i_we    (w_we_a),
        .i_waddr (addr_of(i_row_index, i_col_index)),
        .i_wdata (i_element_value[DATA_WIDTH-1:0]),
        .i_raddr (addr_of(r_row, r_j)),
        .o_rdata (w_a_data)
    );

    imm_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH), .AW(AW)) u_store_b (
        .i_clk   (i_clk),
        .i_we    (w_we_b),
        .i_waddr (addr_of(i_row_index, i_col_index)),
        .i_wdata (i_element_value[DATA_WIDTH-1:0]),
        .i_raddr (addr_of(r_j, r_col)),
        .o_rdata (w_b_data)
    );

    imm_mac #(.DATA_WIDTH(DATA_WIDTH)) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (r_rd_ctl),
        .i_a     (signed'(w_a_data)),
        .i_b     (signed'(w_b_data)),
        .o_acc   (w_acc),
        .o_done  (w_mac_done)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_is_mult) begin
                    n_state = w_mismatch ? ST_OUT : ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (w_issue_last) begin
                    n_state = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (w_mac_done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = r_out_last ? ST_IDLE : ST_ISSUE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        w_issue     = 1'b0;
        w_capture   = 1'b0;
        unique case (r_state)
            ST_IDLE:  o_in_ready  = 1'b1;
            ST_ISSUE: w_issue     = 1'b1;
            ST_WAIT:  w_capture   = w_mac_done;
            ST_OUT:   o_out_valid = 1'b1;
            default: ;
        endcase
    end

    // counters and output word
    always_comb begin
        n_row        = r_row;
        n_col        = r_col;
        n_j          = r_j;
        n_out_value  = r_out_value;
        n_out_row    = r_out_row;
        n_out_col    = r_out_col;
        n_out_last   = r_out_last;
        n_out_status = r_out_status;

        if (w_is_mult) begin
            n_row = '0;
            n_col = '0;
            n_j   = '0;
            if (w_mismatch) begin
                n_out_value  = '0;
                n_out_row    = '0;
                n_out_col    = '0;
                n_out_last   = 1'b1;
                n_out_status = 1'b1;
            end
        end

        if (w_issue) begin
            n_j = r_j + IDX_W'(1);
        end

        if (w_capture) begin
            n_out_value  = OUT_W'(w_acc);
            n_out_row    = r_row;
            n_out_col    = r_col;
            n_out_last   = ((DIM_W'(r_row) + DIM_W'(1)) == r_rows_a)
                        && ((DIM_W'(r_col) + DIM_W'(1)) == r_cols_b);
            n_out_status = 1'b0;
        end

        // next element in row-major order
        if (w_out_take && !r_out_last) begin
            n_j = '0;
            if ((DIM_W'(r_col) + DIM_W'(1)) == r_cols_b) begin
                n_col = '0;
                n_row = r_row + IDX_W'(1);
            end else begin
                n_col = r_col + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_rows_a <= DIM_W'(1);
            r_cols_a <= DIM_W'(1);
            r_rows_b <= DIM_W'(1);
            r_cols_b <= DIM_W'(1);
            r_row    <= '0;
            r_col    <= '0;
            r_j      <= '0;
            r_rd_ctl <= '0;
        end else begin
            r_state  <= n_state;
            r_row    <= n_row;
            r_col    <= n_col;
            r_j      <= n_j;
            // tags line up with the registered RAM read data
            r_rd_ctl <= '{valid: w_issue, first: (r_j == '0), last: w_issue_last};
            if (i_cfg_we) begin
                // dimensions are kept already clipped to the store size
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_ROWS_A: r_rows_a <= eff_dim(i_cfg_data, w_max_dim);
                    CFG_COLS_A: r_cols_a <= eff_dim(i_cfg_data, w_max_dim);
                    CFG_ROWS_B: r_rows_b <= eff_dim(i_cfg_data, w_max_dim);
                    CFG_COLS_B: r_cols_b <= eff_dim(i_cfg_data, w_max_dim);
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_value  <= n_out_value;
        r_out_row    <= n_out_row;
        r_out_col    <= n_out_col;
        r_out_last   <= n_out_last;
        r_out_status <= n_out_status;
    end

    assign o_product_value = r_out_value;
    assign o_out_row       = r_out_row;
    assign o_out_col       = r_out_col;
    assign o_last          = r_out_last;
    assign o_status        = r_out_status;

    `IMM_ASSERT_NOW(a_done_in_wait, w_mac_done, r_state == ST_WAIT, "MAC result outside wait")
    `IMM_ASSERT_NOW(a_j_in_range, r_state == ST_ISSUE, DIM_W'(r_j) < r_cols_a, "inner index past cols_a")
    `IMM_ASSERT_NOW(a_status_word, o_out_valid && o_status, o_last && (o_product_value == '0), "bad mismatch word")
    `IMM_ASSERT_NEXT(a_last_to_idle, w_out_take && o_last, o_in_ready, "no return to idle after last word")

endmodule

`default_nettype wire

@@ design/imm_ram.sv @@
`default_nettype none

module imm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ design/imm_mac.sv @@
`default_nettype none

module imm_mac import imm_pkg::*; #(
    parameter int DATA_WIDTH = 32
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire t_mac_ctl                     i_ctl,
    input  wire logic signed [DATA_WIDTH-1:0] i_a,
    input  wire logic signed [DATA_WIDTH-1:0] i_b,
    output logic signed      [DATA_WIDTH-1:0] o_acc,
    output logic                              o_done
);

    logic signed [2*DATA_WIDTH-1:0] w_prod;
    logic        [DATA_WIDTH-1:0]   r_prod;
    t_mac_ctl                       r_prod_ctl;
    logic        [DATA_WIDTH-1:0]   r_acc;
    logic        [DATA_WIDTH-1:0]   n_acc;
    logic                           r_done;

    // only the low half matters: the sum wraps at DATA_WIDTH bits
    assign w_prod = i_a * i_b;
    assign n_acc  = (r_prod_ctl.first ? '0 : r_acc) + r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prod_ctl <= '0;
            r_done     <= 1'b0;
        end else begin
            r_prod_ctl <= i_ctl;
            r_done     <= r_prod_ctl.valid & r_prod_ctl.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= w_prod[DATA_WIDTH-1:0];
        if (r_prod_ctl.valid) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc  = signed'(r_acc);
    assign o_done = r_done;

endmodule

`default_nettype wire

@@ sim/integer_matrix_multiply_tb.sv @@
`timescale 1ns / 100ps

module integer_matrix_multiply_tb import imm_pkg::*;;

    localparam int DIM_MAX      = 8;
    localparam int RANDOM_WORDS = 450;
    localparam int LONG_HOLD    = 300;
    localparam int IDLE_LIMIT   = 2000;
    localparam int SETTLE       = 8;
    localparam int TAIL         = 20;

    // reserved operation code, ignored by the block
    localparam logic [OP_W-1:0] OP_RESERVED = 2'd3;

    typedef struct packed {
        logic [OUT_W-1:0] value;
        logic [IDX_W-1:0] row;
        logic [IDX_W-1:0] col;
        logic             last;
        logic             status;
    } t_elem;

    // Mirrors both operand stores and the dimension registers; queues the
    // product elements each multiply word should produce.
    class product_predictor;
        logic [OUT_W-1:0] a_val [DIM_MAX*DIM_MAX];
        logic [OUT_W-1:0] b_val [DIM_MAX*DIM_MAX];
        bit               a_set [DIM_MAX*DIM_MAX];
        bit               b_set [DIM_MAX*DIM_MAX];
        logic [DIM_W-1:0] dims [4];
        t_elem            expected_elements [$];
        int               errors;

        function new();
            foreach (dims[i]) dims[i] = 1;
            foreach (a_set[i]) begin
                a_set[i] = 1'b0;
                b_set[i] = 1'b0;
            end
            errors = 0;
        endfunction

        function void set_dim(t_cfg_idx idx, logic [DIM_W-1:0] value);
            dims[idx] = value;
        endfunction

        // zero behaves as one, anything past the store size is clipped
        function int dim_of(t_cfg_idx idx);
            if (dims[idx] == 0) return 1;
            if (dims[idx] > DIM_MAX) return DIM_MAX;
            return int'(dims[idx]);
        endfunction

        function bit takes_effect(logic [OP_W-1:0] op, logic [IDX_W-1:0] r,
                                  logic [IDX_W-1:0] c);
            case (op)
                OP_LOAD_A:   return r < dim_of(CFG_ROWS_A) && c < dim_of(CFG_COLS_A);
                OP_LOAD_B:   return r < dim_of(CFG_ROWS_B) && c < dim_of(CFG_COLS_B);
                OP_MULTIPLY: return 1'b1;
                default:     return 1'b0;
            endcase
        endfunction

        function void note_word(logic [OP_W-1:0] op, logic [IDX_W-1:0] r,
                                logic [IDX_W-1:0] c, logic [OUT_W-1:0] v);
            int    ra, ca, rb, cb;
            t_elem e;
            logic [OUT_W-1:0] acc;
            ra = dim_of(CFG_ROWS_A);
            ca = dim_of(CFG_COLS_A);
            rb = dim_of(CFG_ROWS_B);
            cb = dim_of(CFG_COLS_B);
            if (!takes_effect(op, r, c)) return;
            case (op)
                OP_LOAD_A: begin
                    a_val[r*DIM_MAX + c] = v;
                    a_set[r*DIM_MAX + c] = 1'b1;
                end
                OP_LOAD_B: begin
                    b_val[r*DIM_MAX + c] = v;
                    b_set[r*DIM_MAX + c] = 1'b1;
                end
                default: begin
                    if (ca != rb) begin
                        e = '0;
                        e.last   = 1'b1;
                        e.status = 1'b1;
                        expected_elements.push_back(e);
                    end else begin
                        for (int i = 0; i < ra; i++) begin
                            for (int k = 0; k < cb; k++) begin
                                acc = '0;
                                // low 32 bits of the product ignore the sign
                                for (int j = 0; j < ca; j++)
                                    acc += a_val[i*DIM_MAX + j] * b_val[j*DIM_MAX + k];
                                e.value  = acc;
                                e.row    = IDX_W'(i);
                                e.col    = IDX_W'(k);
                                e.last   = (i == ra - 1) && (k == cb - 1);
                                e.status = 1'b0;
                                expected_elements.push_back(e);
                            end
                        end
                    end
                end
            endcase
        endfunction

        function void check_element(t_elem got);
            t_elem want;
            if (expected_elements.size() == 0) begin
                $display("%0t: unexpected word value=%h row=%0d col=%0d last=%b status=%b",
                         $time, got.value, got.row, got.col, got.last, got.status);
                errors++;
                return;
            end
            want = expected_elements.pop_front();
            if (got !== want) begin
                $display("%0t: mismatch expected value=%h row=%0d col=%0d last=%b status=%b",
                         $time, want.value, want.row, want.col, want.last, want.status);
                $display("%0t:          actual   value=%h row=%0d col=%0d last=%b status=%b",
                         $time, got.value, got.row, got.col, got.last, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]    i_cfg_index = CFG_ROWS_A;
    logic [DIM_W-1:0]        i_cfg_data = '0;
    logic                    i_in_valid = 1'b0;
    logic                    o_in_ready;
    logic [OP_W-1:0]         i_operation = OP_LOAD_A;
    logic [IDX_W-1:0]        i_row_index = '0;
    logic [IDX_W-1:0]        i_col_index = '0;
    logic signed [OUT_W-1:0] i_element_value = '0;
    logic                    o_out_valid;
    logic                    i_out_ready = 1'b0;
    logic signed [OUT_W-1:0] o_product_value;
    logic [IDX_W-1:0]        o_out_row;
    logic [IDX_W-1:0]        o_out_col;
    logic                    o_last;
    logic                    o_status;

    product_predictor board;
    bit quiet = 1'b0;
    bit hold_request = 1'b0;
    int words_done = 0;
    int idle_cycles = 0;

    integer_matrix_multiply uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_row_index     (i_row_index),
        .i_col_index     (i_col_index),
        .i_element_value (i_element_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_product_value (o_product_value),
        .o_out_row       (o_out_row),
        .o_out_col       (o_out_col),
        .o_last          (o_last),
        .o_status        (o_status)
    );

    always #6 i_clk = ~i_clk;

    // mostly back to back, sometimes a short gap, rarely a long one
    function automatic int pick_gap();
        int roll;
        if (quiet) return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [OUT_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '1;
            3:       return '0;
            4, 5:    return OUT_W'($urandom_range(0, 16)) - OUT_W'(8);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [IDX_W-1:0] r,
                             input logic [IDX_W-1:0] c, input logic [OUT_W-1:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_row_index     <= r;
        i_col_index     <= c;
        i_element_value <= v;
        do @(posedge i_clk); while (!o_in_ready);
        if (board.takes_effect(op, r, c)) words_done++;
        board.note_word(op, r, c, v);
    endtask

    // loads are written at once; the extra cycles cover a trailing load
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (board.expected_elements.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic put_reg(input t_cfg_idx idx, input logic [DIM_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        @(posedge i_clk);
        board.set_dim(idx, value);
    endtask

    task automatic write_dims(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ca,
                              input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb);
        drain_results();
        put_reg(CFG_ROWS_A, ra);
        put_reg(CFG_COLS_A, ca);
        put_reg(CFG_ROWS_B, rb);
        put_reg(CFG_COLS_B, cb);
        i_cfg_we <= 1'b0;
    endtask

    // every operand entry a multiply reads must have been written first
    task automatic fill_operands();
        int ra, ca, cb;
        ra = board.dim_of(CFG_ROWS_A);
        ca = board.dim_of(CFG_COLS_A);
        cb = board.dim_of(CFG_COLS_B);
        if (ca != board.dim_of(CFG_ROWS_B)) return;
        for (int i = 0; i < ra; i++)
            for (int j = 0; j < ca; j++)
                if (!board.a_set[i*DIM_MAX + j])
                    send_word(OP_LOAD_A, IDX_W'(i), IDX_W'(j), pick_value());
        for (int j = 0; j < ca; j++)
            for (int k = 0; k < cb; k++)
                if (!board.b_set[j*DIM_MAX + k])
                    send_word(OP_LOAD_B, IDX_W'(j), IDX_W'(k), pick_value());
    endtask

    task automatic random_phase(input logic [DIM_W-1:0] ra, input logic [DIM_W-1:0] ca,
                                input logic [DIM_W-1:0] rb, input logic [DIM_W-1:0] cb,
                                input int rounds, input bit hold_first);
        int n, roll;
        write_dims(ra, ca, rb, cb);
        quiet = ($urandom_range(0, 3) == 0);
        for (int round = 0; round < rounds; round++) begin
            n = $urandom_range(0, 10);
            repeat (n) begin
                roll = $urandom_range(0, 9);
                if (roll == 0)
                    send_word(OP_RESERVED, IDX_W'($urandom), IDX_W'($urandom), $urandom);
                else if (roll == 1)
                    send_word($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A,
                              IDX_W'($urandom), IDX_W'($urandom), pick_value());
                else if (roll < 6)
                    send_word(OP_LOAD_A,
                              IDX_W'($urandom_range(0, board.dim_of(CFG_ROWS_A) - 1)),
                              IDX_W'($urandom_range(0, board.dim_of(CFG_COLS_A) - 1)),
                              pick_value());
                else
                    send_word(OP_LOAD_B,
                              IDX_W'($urandom_range(0, board.dim_of(CFG_ROWS_B) - 1)),
                              IDX_W'($urandom_range(0, board.dim_of(CFG_COLS_B) - 1)),
                              pick_value());
            end
            fill_operands();
            // the sink sits on its ready while the next round keeps offering
            if (hold_first && round == 0) hold_request = 1'b1;
            send_word(OP_MULTIPLY, IDX_W'($urandom), IDX_W'($urandom), $urandom);
        end
    endtask

    initial begin : result_sink
        int    stall_left;
        t_elem got;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && i_out_ready) begin
                got.value  = o_product_value;
                got.row    = o_out_row;
                got.col    = o_out_col;
                got.last   = o_last;
                got.status = o_status;
                board.check_element(got);
            end
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end else if (stall_left == 0) begin
                stall_left = pick_gap();
            end else begin
                stall_left--;
            end
            i_out_ready <= (stall_left == 0);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
            $display("** integer_matrix_multiply: FAILED **");
            $finish;
        end
    end

    initial begin : stimulus
        int kind, k;
        logic [DIM_W-1:0] ra, ca, rb, cb;
        board = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset dimensions are 1x1; out-of-range loads and the reserved op drop out
        send_word(OP_LOAD_A, 3'd0, 3'd0, 32'h7FFF_FFFF);
        send_word(OP_LOAD_B, 3'd0, 3'd0, 32'h8000_0000);
        send_word(OP_RESERVED, 3'd7, 3'd7, 32'hFFFF_FFFF);
        send_word(OP_LOAD_A, 3'd7, 3'd7, 32'h0000_0000);
        send_word(OP_LOAD_B, 3'd0, 3'd1, 32'h0000_0001);
        send_word(OP_LOAD_A, 3'd1, 3'd0, 32'h0000_0002);
        send_word(OP_MULTIPLY, 3'd0, 3'd0, 32'h0);

        // zero row count acts as one, 15 clips to 8; inner sizes disagree
        write_dims(4'd0, 4'd2, 4'd1, 4'd15);
        send_word(OP_MULTIPLY, 3'd7, 3'd7, 32'hFFFF_FFFF);

        // 1x2 times 2x1; min*min wraps to zero, so the sum is one
        write_dims(4'd1, 4'd2, 4'd2, 4'd0);
        send_word(OP_LOAD_A, 3'd0, 3'd1, 32'hFFFF_FFFF);
        send_word(OP_LOAD_B, 3'd1, 3'd0, 32'hFFFF_FFFF);
        send_word(OP_LOAD_A, 3'd0, 3'd0, 32'h8000_0000);
        send_word(OP_LOAD_B, 3'd0, 3'd0, 32'h8000_0000);
        send_word(OP_LOAD_A, 3'd0, 3'd2, 32'h1234_5678);
        send_word(OP_MULTIPLY, 3'd0, 3'd0, 32'h0);

        random_phase(4'd3, 4'd4, 4'd4, 4'd3, 2, 1'b1);
        random_phase(4'd15, 4'd15, 4'd15, 4'd15, 1, 1'b0);
        random_phase(4'd8, 4'd8, 4'd8, 4'd8, 1, 1'b0);
        random_phase(4'd0, 4'd0, 4'd0, 4'd0, 2, 1'b0);

        while (words_done < RANDOM_WORDS) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
                k  = $urandom_range(1, 4);
                ra = DIM_W'($urandom_range(0, 3));
                ca = DIM_W'(k);
                rb = (k == 1 && $urandom_range(0, 1) == 1) ? 4'd0 : DIM_W'(k);
                cb = DIM_W'($urandom_range(0, 3));
            end else if (kind < 8) begin
                k  = $urandom_range(1, 8);
                ra = DIM_W'($urandom_range(0, 15));
                ca = DIM_W'(k);
                rb = DIM_W'(k % DIM_MAX + 1);
                cb = DIM_W'($urandom_range(0, 15));
            end else begin
                ra = DIM_W'($urandom_range(0, 15));
                ca = DIM_W'($urandom_range(0, 15));
                rb = DIM_W'($urandom_range(0, 15));
                cb = DIM_W'($urandom_range(0, 15));
            end
            random_phase(ra, ca, rb, cb, $urandom_range(1, 3), 1'b0);
        end

        i_in_valid <= 1'b0;
        while (board.expected_elements.size() != 0) @(posedge i_clk);
        repeat (TAIL) @(posedge i_clk);
        if (board.errors == 0)
            $display("** integer_matrix_multiply: PASSED **");
        else
            $display("** integer_matrix_multiply: FAILED **");
        $finish;
    end

endmodule
